### hw/rtl/udff_pkg.sv
// ============================================================================
// udff_pkg
// Shared types and constants of the unsigned decimal field formatter.
// ============================================================================
`default_nettype none

package udff_pkg;

    localparam int VAL_W  = 32;   // value width
    localparam int FW_W   = 6;    // field width / precision magnitude width
    localparam int PRC_W  = 7;    // raw precision port width (signed)
    localparam int CHAR_W = 8;    // output character width
    localparam int DIG_W  = 4;    // one decimal digit
    localparam int DIG_N  = 10;   // max decimal digits of a 32-bit value
    localparam int CNT_W  = 4;    // digit count, holds 0..DIG_N

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    // floor(x / 10) == (x * RECIP10) >> 35 for every 32-bit x
    localparam logic [VAL_W-1:0] RECIP10     = 32'hCCCC_CCCD;
    localparam int               RECIP_SHIFT = 35;

    // Job queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;

    // One classified item
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [FW_W-1:0]  width;      // saturated field width
        logic [FW_W-1:0]  prec;       // saturated precision, 0 when none
        logic             has_prec;
        logic             left;
        logic             zpad;
        logic             no_digits;  // zero value with precision 0
    } job_t;

    // Back-end sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CONV,
        PH_SIZE,
        PH_LEAD,
        PH_ZERO,
        PH_DIGIT,
        PH_TRAIL
    } phase_t;

endpackage

`default_nettype wire

### hw/rtl/unsigned_decimal_field_formatter.sv
// ============================================================================
// unsigned_decimal_field_formatter
// printf %u style formatter: one value in, one ASCII character per beat out.
// ============================================================================
// Each input beat carries a 32-bit value, a field width, a precision (any
// negative value means none) and the left-justify and zero-pad flags. The
// block sends the formatted field one character per output beat: leading
// spaces, leading zeros, the decimal digits, then trailing spaces, with
// m_last on the final character. A zero value with precision 0 and width 0
// produces no beats at all. Width and precision saturate at MAX_FIELD. A
// two-entry job queue sits between the input side and the character engine,
// so up to two further items are taken while a field is being sent. One item
// occupies the engine for a queue pop, a conversion phase of D digits (0 to
// 10, one digit per cycle from the divide-by-ten unit), a sizing step, and
// its N characters, one per cycle through the output register unless the
// output stalls, with a phase change step after each section but the last;
// the longest case is a full 32-character field of a ten-digit value.
// ============================================================================
`default_nettype none

module unsigned_decimal_field_formatter #(
    parameter int MAX_FIELD = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [udff_pkg::VAL_W-1:0]        s_value,
    input  wire logic [udff_pkg::FW_W-1:0]         s_field_width,
    input  wire logic signed [udff_pkg::PRC_W-1:0] s_min_digits,
    input  wire logic                              s_left_justify,
    input  wire logic                              s_zero_pad,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [udff_pkg::CHAR_W-1:0]            m_character,
    output logic                                   m_last
);
    import udff_pkg::*;

    logic q_full;
    logic q_push;
    job_t q_in_job;
    logic q_pop;
    logic q_valid;
    job_t q_head_job;

    // Input side
    udff_front #(
        .MAX_FIELD (MAX_FIELD)
    ) u_front (
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_value        (s_value),
        .s_field_width  (s_field_width),
        .s_min_digits   (s_min_digits),
        .s_left_justify (s_left_justify),
        .s_zero_pad     (s_zero_pad),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_job          (q_in_job)
    );

    // Job queue
    udff_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (q_in_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_job   (q_head_job)
    );

    // Character engine
    udff_back #(
        .MAX_FIELD (MAX_FIELD)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_job       (q_head_job),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

endmodule

`default_nettype wire

### hw/rtl/udff_front.sv
// ============================================================================
// udff_front
// Input side: takes a beat, saturates width and precision, decodes the
// precision sign and flags, and pushes a job into the queue.
// ============================================================================
`default_nettype none

module udff_front #(
    parameter int MAX_FIELD = 32
) (
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [udff_pkg::VAL_W-1:0]      s_value,
    input  wire logic [udff_pkg::FW_W-1:0]       s_field_width,
    input  wire logic signed [udff_pkg::PRC_W-1:0] s_min_digits,
    input  wire logic                            s_left_justify,
    input  wire logic                            s_zero_pad,
    input  wire logic                            q_full,
    output logic                                 q_push,
    output udff_pkg::job_t                       q_job
);
    import udff_pkg::*;

    logic            has_prec;
    logic [FW_W-1:0] prec_raw;
    logic [FW_W-1:0] width_sat;
    logic [FW_W-1:0] prec_sat;

    // Handshake: accept whenever the queue has room
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // Classification
    always_comb begin
        has_prec = !s_min_digits[PRC_W-1];
        prec_raw = has_prec ? s_min_digits[FW_W-1:0] : '0;

        if (32'(s_field_width) > MAX_FIELD) begin
            width_sat = FW_W'(MAX_FIELD);
        end else begin
            width_sat = s_field_width;
        end
        if (32'(prec_raw) > MAX_FIELD) begin
            prec_sat = FW_W'(MAX_FIELD);
        end else begin
            prec_sat = prec_raw;
        end

        q_job.value     = s_value;
        q_job.width     = width_sat;
        q_job.prec      = prec_sat;
        q_job.has_prec  = has_prec;
        q_job.left      = s_left_justify;
        q_job.zpad      = s_zero_pad;
        q_job.no_digits = (s_value == '0) && has_prec && (prec_sat == '0);
    end

endmodule

`default_nettype wire

### hw/rtl/udff_queue.sv
// ============================================================================
// udff_queue
// Short job queue that decouples the input side from the character engine.
// ============================================================================
`default_nettype none

module udff_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire udff_pkg::job_t push_job,
    output logic                full,
    input  wire logic           pop,
    output logic                head_valid,
    output udff_pkg::job_t      head_job
);
    import udff_pkg::*;

    localparam int CNT_QW = $clog2(QDEPTH + 1);

    job_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [CNT_QW-1:0] cnt_reg;

    assign full       = (cnt_reg == CNT_QW'(QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Checks
    a_no_overflow : assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("udff_queue: push into full queue");
    a_no_underflow : assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("udff_queue: pop from empty queue");
    a_cnt_range : assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_QW'(QDEPTH))
        else $error("udff_queue: fill count out of range");

endmodule

`default_nettype wire

### hw/rtl/udff_back.sv
// ============================================================================
// udff_back
// Character engine: converts the value to decimal one digit per cycle,
// sizes the padding, then sends leading spaces, zeros, digits and trailing
// spaces one beat per cycle, unless the output stalls, through a registered output stage.
// ============================================================================
`default_nettype none

module udff_back #(
    parameter int MAX_FIELD = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          q_valid,
    input  wire udff_pkg::job_t                q_job,
    output logic                               q_pop,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [udff_pkg::CHAR_W-1:0]        m_character,
    output logic                               m_last
);
    import udff_pkg::*;

    // Wide enough for any pad count or field length
    localparam int CW = $clog2(MAX_FIELD + DIG_N + 1);

    phase_t            state_reg, state_next;
    job_t              job_reg;
    logic [VAL_W-1:0]  t_reg;
    logic [CNT_W-1:0]  nd_reg;
    logic [DIG_W-1:0]  digit_store [DIG_N];
    logic [CW-1:0]     lead_reg, zeros_reg, trail_reg, total_reg;
    logic              m_valid_reg;
    logic [CHAR_W-1:0] m_character_reg;
    logic              m_last_reg;

    // Divide-by-ten unit
    logic [2*VAL_W-1:0] prod;
    logic [VAL_W-1:0]   quot;
    logic [VAL_W-1:0]   rem_full;
    logic [DIG_W-1:0]   rem;

    // Sizing
    logic [CW-1:0] wid_c, prec_c, nd_c, zeros_c, body_c, spaces_c;

    // Control
    logic              out_free;
    logic              emit;
    logic [CHAR_W-1:0] emit_char;
    logic [CNT_W-1:0]  dig_idx;

    assign m_valid     = m_valid_reg;
    assign m_character = m_character_reg;
    assign m_last      = m_last_reg;
    assign out_free    = !m_valid_reg || m_ready;
    assign dig_idx     = nd_reg - 1'b1;

    // Reciprocal multiply: quotient and remainder of t / 10
    always_comb begin
        prod     = {{VAL_W{1'b0}}, t_reg} * {{VAL_W{1'b0}}, RECIP10};
        quot     = VAL_W'(prod[2*VAL_W-1:RECIP_SHIFT]);
        rem_full = t_reg - ((quot << 3) + (quot << 1));
        rem      = rem_full[DIG_W-1:0];
    end

    // Pad sizing from digit count and options
    always_comb begin
        wid_c  = CW'(job_reg.width);
        prec_c = CW'(job_reg.prec);
        nd_c   = CW'(nd_reg);
        zeros_c = '0;
        if (job_reg.has_prec) begin
            if (prec_c > nd_c) begin
                zeros_c = prec_c - nd_c;
            end
        end else if (job_reg.zpad && !job_reg.left) begin
            if (wid_c > nd_c) begin
                zeros_c = wid_c - nd_c;
            end
        end
        body_c   = zeros_c + nd_c;
        spaces_c = (wid_c > body_c) ? (wid_c - body_c) : '0;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            PH_IDLE: begin
                if (q_valid) begin
                    state_next = q_job.no_digits ? PH_SIZE : PH_CONV;
                end
            end
            PH_CONV: begin
                if (quot == '0 || nd_reg == CNT_W'(DIG_N - 1)) begin
                    state_next = PH_SIZE;
                end
            end
            PH_SIZE: begin
                state_next = ((spaces_c + body_c) == '0) ? PH_IDLE : PH_LEAD;
            end
            PH_LEAD: begin
                if (lead_reg == '0) begin
                    state_next = PH_ZERO;
                end else if (out_free && total_reg == CW'(1)) begin
                    state_next = PH_IDLE;
                end
            end
            PH_ZERO: begin
                if (zeros_reg == '0) begin
                    state_next = PH_DIGIT;
                end else if (out_free && total_reg == CW'(1)) begin
                    state_next = PH_IDLE;
                end
            end
            PH_DIGIT: begin
                if (nd_reg == '0) begin
                    state_next = PH_TRAIL;
                end else if (out_free && total_reg == CW'(1)) begin
                    state_next = PH_IDLE;
                end
            end
            PH_TRAIL: begin
                if (out_free && total_reg == CW'(1)) begin
                    state_next = PH_IDLE;
                end
            end
            default: begin
                state_next = PH_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        q_pop     = 1'b0;
        emit      = 1'b0;
        emit_char = CH_SPACE;
        case (state_reg)
            PH_IDLE: begin
                q_pop = q_valid;
            end
            PH_LEAD: begin
                emit = out_free && (lead_reg != '0);
            end
            PH_ZERO: begin
                emit      = out_free && (zeros_reg != '0);
                emit_char = CH_ZERO;
            end
            PH_DIGIT: begin
                emit      = out_free && (nd_reg != '0);
                emit_char = CH_ZERO + CHAR_W'(digit_store[dig_idx]);
            end
            PH_TRAIL: begin
                emit = out_free && (trail_reg != '0);
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // Sequencer state and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= PH_IDLE;
            nd_reg    <= '0;
            lead_reg  <= '0;
            zeros_reg <= '0;
            trail_reg <= '0;
            total_reg <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                PH_IDLE: begin
                    if (q_valid) begin
                        nd_reg <= '0;
                    end
                end
                PH_CONV: begin
                    nd_reg <= nd_reg + 1'b1;
                end
                PH_SIZE: begin
                    lead_reg  <= job_reg.left ? '0 : spaces_c;
                    trail_reg <= job_reg.left ? spaces_c : '0;
                    zeros_reg <= zeros_c;
                    total_reg <= spaces_c + body_c;
                end
                PH_LEAD: begin
                    if (emit) begin
                        lead_reg <= lead_reg - 1'b1;
                    end
                end
                PH_ZERO: begin
                    if (emit) begin
                        zeros_reg <= zeros_reg - 1'b1;
                    end
                end
                PH_DIGIT: begin
                    if (emit) begin
                        nd_reg <= nd_reg - 1'b1;
                    end
                end
                PH_TRAIL: begin
                    if (emit) begin
                        trail_reg <= trail_reg - 1'b1;
                    end
                end
                default: begin
                    nd_reg <= nd_reg;
                end
            endcase
            if (emit) begin
                total_reg <= total_reg - 1'b1;
            end
        end
    end

    // Job capture and running quotient
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_reg <= q_job;
            t_reg   <= q_job.value;
        end else if (state_reg == PH_CONV) begin
            t_reg <= quot;
        end
    end

    // Digit store, least significant digit first
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIG_N; i++) begin
                digit_store[i] <= '0;
            end
        end else if (state_reg == PH_CONV) begin
            digit_store[nd_reg] <= rem;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_character_reg <= emit_char;
            m_last_reg      <= (total_reg == CW'(1));
        end
    end

    // Checks
    a_nd_range : assert property (@(posedge aclk) disable iff (!aresetn)
        nd_reg <= CNT_W'(DIG_N))
        else $error("udff_back: digit count out of range");
    a_emit_budget : assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (total_reg != '0))
        else $error("udff_back: beat beyond field length");
    a_last_ends : assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && total_reg == CW'(1)) |=> (state_reg == PH_IDLE && m_last_reg))
        else $error("udff_back: field did not close on last beat");
    a_conv_live : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == PH_CONV) |-> (t_reg != '0 || nd_reg == '0))
        else $error("udff_back: conversion ran past the top digit");

endmodule

`default_nettype wire

### bench/tb_unsigned_decimal_field_formatter.sv
// ============================================================================
// tb_unsigned_decimal_field_formatter
// Self-checking bench for the printf %u style field formatter.
// ============================================================================
// A short directed table covers the edges: zero values, empty fields, the
// padding rules, saturation of width and precision, and negative precision.
// A random part follows, with mostly small fields. Typed directed rows queue
// their own text; other beats go through a local formatting function, and
// each character that should come out is queued. Output beats are compared
// in order against that queue. The sender works in bursts, the receiver
// stalls on its own pattern, with one long hold-off and two full drains.
// ============================================================================
`default_nettype none

module tb_unsigned_decimal_field_formatter;

    import udff_pkg::*;

    localparam int MAX_FIELD      = 32;
    localparam int RESET_CYCLES   = 11;
    localparam int RAND_ITEMS     = 450;
    localparam int HOLD_AT        = 150;
    localparam int DRAIN_AT       = 320;
    localparam int HOLD_CYCLES    = 300;
    localparam int TAIL_CYCLES    = 100;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PRINT_CAP      = 50;

    localparam logic [PRC_W-1:0] NO_PREC = 7'h7F;   // -1: no precision

    // One input beat
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [FW_W-1:0]  fw;
        logic [PRC_W-1:0] md;
        logic             lj;
        logic             zp;
    } field_req_t;

    // One output beat
    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } char_beat_t;

    // Directed row: typed rows carry their expected text, right aligned
    typedef struct packed {
        field_req_t  req;
        logic        typed;
        logic [3:0]  nchar;
        logic [79:0] text;
    } dir_row_t;

    typedef enum int {
        RX_FREE,
        RX_COIN,
        RX_SPARSE,
        RX_RHYTHM
    } rx_mode_t;

    typedef logic [CHAR_W-1:0] char_q_t [$];

    localparam int DIR_N = 23;

    logic                     aclk           = 1'b0;
    logic                     aresetn        = 1'b0;
    logic                     s_valid        = 1'b0;
    logic                     s_ready;
    logic [VAL_W-1:0]         s_value        = '0;
    logic [FW_W-1:0]          s_field_width  = '0;
    logic signed [PRC_W-1:0]  s_min_digits   = '0;
    logic                     s_left_justify = 1'b0;
    logic                     s_zero_pad     = 1'b0;
    logic                     m_valid;
    logic                     m_ready        = 1'b0;
    logic [CHAR_W-1:0]        m_character;
    logic                     m_last;

    char_beat_t expected_chars [$];
    char_beat_t want;
    int         error_count = 0;
    int         beat_count  = 0;
    int         idle_cycles = 0;
    bit         hold_req    = 1'b0;
    bit         hold_active = 1'b0;
    dir_row_t   dir_rows [DIR_N];

    unsigned_decimal_field_formatter #(
        .MAX_FIELD(MAX_FIELD)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value       (s_value),
        .s_field_width (s_field_width),
        .s_min_digits  (s_min_digits),
        .s_left_justify(s_left_justify),
        .s_zero_pad    (s_zero_pad),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_character   (m_character),
        .m_last        (m_last)
    );

    // 12-unit clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Characters that one request should produce, in order
    function automatic char_q_t format_field(field_req_t req);
        char_q_t          chars;
        int               width;
        int               prec;
        int               nd;
        int               zeros;
        int               body;
        int               spaces;
        int               k;
        bit               has_prec;
        logic [DIG_W-1:0] digits [DIG_N];
        logic [VAL_W-1:0] rest;
        has_prec = !req.md[PRC_W-1];
        width    = (req.fw > MAX_FIELD) ? MAX_FIELD : int'(req.fw);
        prec     = has_prec ? int'(req.md[PRC_W-2:0]) : 0;
        if (prec > MAX_FIELD) prec = MAX_FIELD;
        // digits, least significant first; none for zero at precision 0
        nd = 0;
        if (!(req.value == 0 && has_prec && prec == 0)) begin
            rest = req.value;
            do begin
                digits[nd] = DIG_W'(rest % 10);
                rest       = rest / 10;
                nd++;
            end while (rest != 0 && nd < DIG_N);
        end
        // zeros pad to precision, or to width when zero-padded
        zeros = 0;
        if (has_prec) begin
            if (prec > nd) zeros = prec - nd;
        end else if (req.zp && !req.lj) begin
            if (width > nd) zeros = width - nd;
        end
        body   = zeros + nd;
        spaces = (width > body) ? width - body : 0;
        if (!req.lj) repeat (spaces) chars.push_back(CH_SPACE);
        repeat (zeros) chars.push_back(CH_ZERO);
        for (k = nd - 1; k >= 0; k--) chars.push_back(CHAR_W'(CH_ZERO + digits[k]));
        if (req.lj) repeat (spaces) chars.push_back(CH_SPACE);
        return chars;
    endfunction

    // Queue a field's characters, last flag on the final one
    task automatic queue_field(char_q_t chars);
        int k;
        for (k = 0; k < chars.size(); k++) begin
            expected_chars.push_back('{character: chars[k], last: (k == chars.size() - 1)});
        end
    endtask

    // Random request, biased to small fields but covering every port bit
    function automatic field_req_t random_req();
        field_req_t       req;
        logic [VAL_W-1:0] p10;
        int               pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0: req.value = '0;
            1: req.value = $urandom_range(0, 9);
            2: req.value = $urandom_range(0, 999);
            3: begin
                p10 = 1;
                repeat ($urandom_range(1, 9)) p10 = p10 * 10;
                req.value = p10 - $urandom_range(0, 1);
            end
            4: req.value = 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: req.value = $urandom();
        endcase
        pick = $urandom_range(0, 9);
        if (pick < 6)      req.fw = FW_W'($urandom_range(0, 12));
        else if (pick < 9) req.fw = FW_W'($urandom_range(0, 33));
        else               req.fw = FW_W'($urandom_range(0, 63));
        pick = $urandom_range(0, 19);
        if (pick < 8)       req.md = NO_PREC;
        else if (pick < 11) req.md = PRC_W'($urandom_range(64, 127));
        else if (pick < 17) req.md = PRC_W'($urandom_range(0, 12));
        else                req.md = PRC_W'($urandom_range(0, 63));
        req.lj = 1'($urandom_range(0, 1));
        req.zp = 1'($urandom_range(0, 1));
        return req;
    endfunction

    // Offer one request and hold it until the block takes it
    task automatic drive_req(field_req_t req);
        s_valid        <= 1'b1;
        s_value        <= req.value;
        s_field_width  <= req.fw;
        s_min_digits   <= req.md;
        s_left_justify <= req.lj;
        s_zero_pad     <= req.zp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic report_mismatch(string what);
        error_count++;
        if (error_count <= PRINT_CAP) $display("mismatch at beat %0d: %s", beat_count, what);
    endtask

    // Sender: directed table, then random requests in bursts
    initial begin
        field_req_t req;
        char_q_t    chars;
        int         i;
        int         k;
        int         burst_left;
        int         gap;
        dir_rows = '{
            // typed: zero, empty field, pad rules
            '{'{32'd0, 6'd0, NO_PREC, 1'b0, 1'b0}, 1'b1, 4'd1, 80'("0")},
            '{'{32'd0, 6'd0, 7'd0,    1'b0, 1'b0}, 1'b1, 4'd0, 80'd0},
            '{'{32'd0, 6'd5, 7'd0,    1'b0, 1'b0}, 1'b1, 4'd5, 80'("     ")},
            '{'{32'd7, 6'd5, NO_PREC, 1'b0, 1'b1}, 1'b1, 4'd5, 80'("00007")},
            '{'{32'd7, 6'd5, NO_PREC, 1'b1, 1'b1}, 1'b1, 4'd5, 80'("7    ")},
            '{'{32'd7, 6'd5, 7'd3,    1'b0, 1'b1}, 1'b1, 4'd5, 80'("  007")},
            '{'{32'd99999, 6'd3, 7'd2, 1'b0, 1'b0}, 1'b1, 4'd5, 80'("99999")},
            '{'{32'd0, 6'd3, 7'd0,    1'b1, 1'b0}, 1'b1, 4'd3, 80'("   ")},
            '{'{32'd0, 6'd0, 7'd1,    1'b0, 1'b0}, 1'b1, 4'd1, 80'("0")},
            '{'{32'd9, 6'd1, NO_PREC, 1'b0, 1'b0}, 1'b1, 4'd1, 80'("9")},
            '{'{32'd10, 6'd0, NO_PREC, 1'b1, 1'b1}, 1'b1, 4'd2, 80'("10")},
            '{'{32'd0, 6'd4, NO_PREC, 1'b0, 1'b1}, 1'b1, 4'd4, 80'("0000")},
            // predicted: saturation, negative precision, full fields
            '{'{32'hFFFF_FFFF, 6'd0, NO_PREC, 1'b0, 1'b0}, 1'b0, 4'd0, 80'd0},
            '{'{32'd123, 6'd63, NO_PREC, 1'b0, 1'b0}, 1'b0, 4'd0, 80'd0},
            '{'{32'd123, 6'd0, 7'd63,    1'b0, 1'b0}, 1'b0, 4'd0, 80'd0},
            '{'{32'd123, 6'd40, NO_PREC, 1'b1, 1'b0}, 1'b0, 4'd0, 80'd0},
            '{'{32'd5, 6'd10, 7'h40,     1'b0, 1'b1}, 1'b0, 4'd0, 80'd0},
            '{'{32'd0, 6'd32, 7'd32,     1'b1, 1'b0}, 1'b0, 4'd0, 80'd0},
            '{'{32'd1000000000, 6'd12, NO_PREC, 1'b0, 1'b1}, 1'b0, 4'd0, 80'd0},
            '{'{32'hFFFF_FFFF, 6'd32, NO_PREC, 1'b0, 1'b1}, 1'b0, 4'd0, 80'd0},
            '{'{32'hFFFF_FFFF, 6'd63, 7'd63,   1'b1, 1'b1}, 1'b0, 4'd0, 80'd0},
            '{'{32'd1, 6'd33, 7'd33,   1'b0, 1'b0}, 1'b0, 4'd0, 80'd0},
            '{'{32'd0, 6'd63, NO_PREC, 1'b0, 1'b1}, 1'b0, 4'd0, 80'd0}
        };
        burst_left = 0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (i = 0; i < DIR_N + RAND_ITEMS; i++) begin
            req = (i < DIR_N) ? dir_rows[i].req : random_req();
            drive_req(req);
            if (i < DIR_N && dir_rows[i].typed) begin
                chars.delete();
                for (k = 0; k < dir_rows[i].nchar; k++) begin
                    chars.push_back(dir_rows[i].text[8*(dir_rows[i].nchar-1-k) +: 8]);
                end
            end else begin
                chars = format_field(req);
            end
            queue_field(chars);
            // pacing: full drain pauses, long receiver hold, random bursts
            if (i == DIR_N - 1 || i == DRAIN_AT) begin
                s_valid <= 1'b0;
                do @(posedge aclk); while (expected_chars.size() != 0);
            end else if (i == HOLD_AT) begin
                hold_req = 1'b1;
            end else if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap        = hold_active ? 0 : $urandom_range(0, 8);
                if (gap != 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end else begin
                burst_left--;
            end
        end
        s_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_chars.size() != 0) report_mismatch("characters never sent");
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Receiver: changing stall modes, plus one long hold-off on request
    initial begin
        rx_mode_t rx_mode;
        int       mode_left;
        int       cyc;
        rx_mode   = RX_FREE;
        mode_left = 0;
        cyc       = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req    = 1'b0;
                hold_active = 1'b1;
                m_ready    <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_active = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 80);
                end
                mode_left--;
                cyc++;
                case (rx_mode)
                    RX_FREE:   m_ready <= 1'b1;
                    RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:   m_ready <= (cyc % 5 < 2);
                endcase
                @(posedge aclk);
            end
        end
    end

    // Output check against the oldest expected character
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected character 0x%02h", m_character));
            end else begin
                want = expected_chars.pop_front();
                if (m_character !== want.character)
                    report_mismatch($sformatf("character 0x%02h, wanted 0x%02h",
                                              m_character, want.character));
                if (m_last !== want.last)
                    report_mismatch($sformatf("last %b, wanted %b", m_last, want.last));
            end
            beat_count++;
        end
    end

    // Watchdog: too long without any beat on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule

`default_nettype wire

### files.f
hw/rtl/udff_pkg.sv
hw/rtl/udff_front.sv
hw/rtl/udff_queue.sv
hw/rtl/udff_back.sv
hw/rtl/unsigned_decimal_field_formatter.sv
bench/tb_unsigned_decimal_field_formatter.sv
